>>> design/capm_pkg.sv
// Package of shared constants and types for the cascaded attitude PID mixer.
package capm_pkg;
  localparam int unsigned SumWidthDef = 32;
  localparam int unsigned GainFracDef = 8;
  localparam int unsigned NumLoops = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DriveW = 18;
  localparam int unsigned ErrW = 17;
  localparam logic [CfgIdxW-1:0] IDX_ROLL_ANG  = 3'd0;
  localparam logic [CfgIdxW-1:0] IDX_ROLL_RATE = 3'd1;
  localparam logic [CfgIdxW-1:0] IDX_PITCH_ANG = 3'd2;
  localparam logic [CfgIdxW-1:0] IDX_PITCH_RATE = 3'd3;
  localparam logic [CfgIdxW-1:0] IDX_YAW_ANG   = 3'd4;
  localparam logic [CfgIdxW-1:0] IDX_YAW_RATE  = 3'd5;
  localparam logic [CfgIdxW-1:0] IDX_HEIGHT    = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;
endpackage

>>> design/cascaded_attitude_pid_mixer.sv
// Top level of the cascaded attitude PID controller with X mixer.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | seven signed 16-bit samples
//  out_    | output    | out_valid/stall  | four signed 18-bit drive words
//  cfg_    | input     | cfg_valid/ready  | 3-bit index, 64-bit data
//
// The seven controllers run one after another on a single shift-and-add
// multiplier that takes one multiplier bit per cycle. Each controller forms
// its error and integral in ST_PREP, its three products (Kp, Ki, Kd) in ST_MUL
// and rounds and stores in ST_FIN; out_valid rises once the height controller
// is done. The input stalls while a word is in progress and while its result
// waits; the next word can be accepted once the result is taken, so a stalled
// result holds off the input.
// Reset is synchronous and clears the state machine, the integrals, the last
// errors and the gain registers; no word is taken on either port while it is held.
module cascaded_attitude_pid_mixer #(
  parameter int unsigned SUM_WIDTH = capm_pkg::SumWidthDef,
  parameter int unsigned GAIN_FRACTION_BITS = capm_pkg::GainFracDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_yaw_angle,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  input  logic signed [15:0] in_height,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [capm_pkg::DriveW-1:0] out_front_drive,
  output logic signed [capm_pkg::DriveW-1:0] out_rear_drive,
  output logic signed [capm_pkg::DriveW-1:0] out_left_drive,
  output logic signed [capm_pkg::DriveW-1:0] out_right_drive,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [capm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int unsigned EW = capm_pkg::ErrW;
  // Accumulator must hold Ki*sum plus two 16x18 products.
  localparam int unsigned AccW = SUM_WIDTH + 16 + 2;
  localparam int unsigned PW = (SUM_WIDTH > 18) ? SUM_WIDTH : 18;

  logic [63:0] loop_r [capm_pkg::NumLoops];
  logic signed [SUM_WIDTH-1:0] sum_r [capm_pkg::NumLoops];
  logic signed [EW-1:0] last_r [capm_pkg::NumLoops];

  capm_pkg::state_t state_r;
  logic [2:0] loop_idx_r;      // controller in progress
  logic [1:0] term_r;          // 0 Kp, 1 Ki, 2 Kd
  logic [3:0] bit_r;           // multiplier bit position
  logic signed [AccW-1:0] acc_r;
  logic signed [PW-1:0] mcand_r;   // multiplicand
  logic [15:0] mplier_r;           // gain, shifted right one bit a cycle
  logic signed [EW-1:0] err_r;
  logic signed [15:0] goal_r;      // inner goal from outer loop
  logic signed [15:0] res_r [3];   // X, Y, Z
  logic signed [15:0] smp_r [7];
  logic signed [capm_pkg::DriveW-1:0] f_r, b_r, l_r, rt_r;
  logic valid_r;

  assign cfg_ready = rst_n;
  assign in_stall = !rst_n || (state_r != capm_pkg::ST_IDLE) || valid_r;
  assign out_valid = valid_r;
  assign out_front_drive = f_r;
  assign out_rear_drive = b_r;
  assign out_left_drive = l_r;
  assign out_right_drive = rt_r;

  // Configuration; rate registers keep only 48 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < capm_pkg::NumLoops; i++) loop_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        capm_pkg::IDX_ROLL_ANG, capm_pkg::IDX_PITCH_ANG, capm_pkg::IDX_YAW_ANG,
        capm_pkg::IDX_HEIGHT:
          loop_r[cfg_index] <= cfg_data;
        capm_pkg::IDX_ROLL_RATE, capm_pkg::IDX_PITCH_RATE, capm_pkg::IDX_YAW_RATE:
          loop_r[cfg_index] <= {16'd0, cfg_data[47:0]};
        default: ;
      endcase
    end
  end

  // Measured value and goal for the current controller.
  logic signed [15:0] meas, goal;
  logic [63:0] reg_cur;
  always_comb begin
    reg_cur = loop_r[loop_idx_r];
    unique case (loop_idx_r)
      capm_pkg::IDX_ROLL_ANG:   meas = smp_r[0];
      capm_pkg::IDX_ROLL_RATE:  meas = smp_r[3];
      capm_pkg::IDX_PITCH_ANG:  meas = smp_r[1];
      capm_pkg::IDX_PITCH_RATE: meas = smp_r[4];
      capm_pkg::IDX_YAW_ANG:    meas = smp_r[2];
      capm_pkg::IDX_YAW_RATE:   meas = smp_r[5];
      default: meas = smp_r[6];
    endcase
    goal = loop_idx_r[0] && (loop_idx_r != capm_pkg::IDX_HEIGHT) ? goal_r
                                                 : $signed(reg_cur[63:48]);
  end

  logic signed [EW-1:0] err_c;
  logic signed [SUM_WIDTH:0] sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat, sum_cur;
  logic signed [EW:0] diff_c;
  logic signed [AccW-1:0] shifted;
  logic signed [15:0] pid_out;
  logic signed [AccW-1:0] addend;
  always_comb begin
    err_c = EW'(goal) - EW'(meas);
    sum_cur = sum_r[loop_idx_r];
    sum_wide = (SUM_WIDTH+1)'(sum_cur) + (SUM_WIDTH+1)'(err_c);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
      sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    else
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    diff_c = (EW+1)'(err_r) - (EW+1)'(last_r[loop_idx_r]);
    shifted = acc_r >>> GAIN_FRACTION_BITS;
    if (shifted > AccW'(32'sd32767)) pid_out = 16'sd32767;
    else if (shifted < -AccW'(32'sd32768)) pid_out = -16'sd32768;
    else pid_out = shifted[15:0];
    // Partial product for one multiplier bit; the top bit weighs negative.
    addend = AccW'(mcand_r) <<< bit_r;
    if (!mplier_r[0]) addend = '0;
    else if (bit_r == 4'd15) addend = -addend;
  end

  logic signed [15:0] x_v, y_v, z_v, h_v;
  assign x_v = res_r[0];
  assign y_v = res_r[1];
  assign z_v = res_r[2];
  assign h_v = pid_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= capm_pkg::ST_IDLE;
      valid_r <= 1'b0;
      loop_idx_r <= '0;
      term_r <= '0;
      bit_r <= '0;
      for (int i = 0; i < capm_pkg::NumLoops; i++) begin
        sum_r[i] <= '0;
        last_r[i] <= '0;
      end
    end else begin
      if (valid_r && !out_stall) valid_r <= 1'b0;
      unique case (state_r)
        capm_pkg::ST_IDLE: begin
          if (in_valid && !valid_r) begin
            smp_r[0] <= in_roll_angle;
            smp_r[1] <= in_pitch_angle;
            smp_r[2] <= in_yaw_angle;
            smp_r[3] <= in_rate_x;
            smp_r[4] <= in_rate_y;
            smp_r[5] <= in_rate_z;
            smp_r[6] <= in_height;
            loop_idx_r <= '0;
            state_r <= capm_pkg::ST_PREP;
          end
        end
        capm_pkg::ST_PREP: begin
          err_r <= err_c;
          sum_r[loop_idx_r] <= sum_sat;
          acc_r <= '0;
          term_r <= 2'd0;
          bit_r <= '0;
          mcand_r <= PW'(err_c);
          mplier_r <= reg_cur[15:0];
          state_r <= capm_pkg::ST_MUL;
        end
        capm_pkg::ST_MUL: begin
          acc_r <= acc_r + addend;
          if (bit_r == 4'd15) begin
            bit_r <= '0;
            if (term_r == 2'd2) begin
              state_r <= capm_pkg::ST_FIN;
            end else begin
              term_r <= term_r + 2'd1;
              mplier_r <= (term_r == 2'd0) ? reg_cur[31:16] : reg_cur[47:32];
              mcand_r <= (term_r == 2'd0) ? PW'(sum_r[loop_idx_r]) : PW'(diff_c);
            end
          end else begin
            bit_r <= bit_r + 4'd1;
            mplier_r <= mplier_r >> 1;
          end
        end
        capm_pkg::ST_FIN: begin
          last_r[loop_idx_r] <= err_r;
          goal_r <= pid_out;
          case (loop_idx_r)
            capm_pkg::IDX_ROLL_RATE:  res_r[0] <= pid_out;
            capm_pkg::IDX_PITCH_RATE: res_r[1] <= pid_out;
            capm_pkg::IDX_YAW_RATE:   res_r[2] <= pid_out;
            default: ;
          endcase
          if (loop_idx_r == capm_pkg::IDX_HEIGHT) begin
            f_r <= 18'(x_v) - 18'(y_v) + 18'(z_v) + 18'(h_v);
            b_r <= -18'(x_v) + 18'(y_v) + 18'(z_v) + 18'(h_v);
            l_r <= 18'(x_v) - 18'(y_v) - 18'(z_v) + 18'(h_v);
            rt_r <= -18'(x_v) + 18'(y_v) - 18'(z_v) + 18'(h_v);
            valid_r <= 1'b1;
            state_r <= capm_pkg::ST_OUT;
          end else begin
            loop_idx_r <= loop_idx_r + 3'd1;
            state_r <= capm_pkg::ST_PREP;
          end
        end
        capm_pkg::ST_OUT: begin
          state_r <= capm_pkg::ST_IDLE;
        end
        default: state_r <= capm_pkg::ST_IDLE;
      endcase
    end
  end
endmodule

>>> design/capm_checker.sv
// Port-level checker for the cascaded attitude PID mixer, bound to the top level.
module capm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [17:0] out_front_drive,
  input logic signed [17:0] out_rear_drive,
  input logic signed [17:0] out_left_drive,
  input logic signed [17:0] out_right_drive
);
  // Mixer identity: front plus rear (2Z+2H) equals left plus right (2H-2Z)
  // plus twice the difference of front and left (2Z).
  a_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (18'(out_front_drive + out_rear_drive) ==
                   18'(out_left_drive + out_right_drive + 18'(out_front_drive
                   - out_left_drive) * 18'sd2)))
    else $error("mixer identity broken");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");
  a_nooutnew: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown with new word");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_front_drive))
    else $error("stalled result changed");
endmodule

bind cascaded_attitude_pid_mixer capm_checker u_capm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_front_drive(out_front_drive), .out_rear_drive(out_rear_drive),
  .out_left_drive(out_left_drive), .out_right_drive(out_right_drive)
);

>>> verif/cascaded_attitude_pid_mixer_tb.sv
// Self-checking testbench for the cascaded attitude PID controller with X mixer.
module cascaded_attitude_pid_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SumW = capm_pkg::SumWidthDef;
  localparam int FracW = capm_pkg::GainFracDef;
  localparam int DrvW = capm_pkg::DriveW;
  localparam int IdxW = capm_pkg::CfgIdxW;
  localparam int Loops = capm_pkg::NumLoops;
  localparam int EW = capm_pkg::ErrW;
  localparam int RandomWords = 1800;
  localparam int SettleCycles = 500;
  localparam int HoldOffCycles = 2000;

  typedef struct {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] height;
  } sample_t;

  typedef struct packed {
    logic signed [DrvW-1:0] front;
    logic signed [DrvW-1:0] rear;
    logic signed [DrvW-1:0] left;
    logic signed [DrvW-1:0] right;
  } drive_t;

  // One row of the directed stimulus. When known is set, the drive values
  // typed into the row are checked against the predictor as well.
  typedef struct {
    sample_t smp;
    bit known;
    drive_t drv;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_roll_angle = '0, in_pitch_angle = '0, in_yaw_angle = '0;
  logic signed [15:0] in_rate_x = '0, in_rate_y = '0, in_rate_z = '0, in_height = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DrvW-1:0] out_front_drive, out_rear_drive;
  logic signed [DrvW-1:0] out_left_drive, out_right_drive;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  cascaded_attitude_pid_mixer uut (.*);

  always #5 clk = ~clk;

  // Predictor state: the gain registers, the integrals and the last errors.
  logic [63:0] gain_regs [Loops];
  logic signed [SumW-1:0] integrals [Loops];
  logic signed [EW-1:0] last_errors [Loops];
  drive_t expected_drives [$];

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_off_reqs = 0;
  int hold_off_seen = 0;
  int hold_off_cycles = 0;
  int error_count = 0;
  int known_error_count = 0;

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // One PID update; the integral saturates at the signed SumW range and the
  // gain-weighted total is shifted down with floor rounding (arithmetic >>>).
  function automatic logic signed [15:0] pid_update(int k, longint goal, longint meas);
    longint kp, ki, kd, err, sum, acc;
    longint smax;
    kp = longint'($signed(gain_regs[k][15:0]));
    ki = longint'($signed(gain_regs[k][31:16]));
    kd = longint'($signed(gain_regs[k][47:32]));
    smax = (longint'(1) <<< (SumW - 1)) - 1;
    err = goal - meas;
    sum = longint'(integrals[k]) + err;
    if (sum > smax) sum = smax;
    if (sum < -smax - 1) sum = -smax - 1;
    integrals[k] = sum[SumW-1:0];
    acc = kp * err + ki * sum + kd * (err - longint'(last_errors[k]));
    last_errors[k] = err[EW-1:0];
    return sat16(acc >>> FracW);
  endfunction

  function automatic drive_t mix_sample(sample_t s);
    longint x, y, z, h;
    drive_t d;
    x = pid_update(0, $signed(gain_regs[0][63:48]), s.roll_angle);
    x = pid_update(1, x, s.rate_x);
    y = pid_update(2, $signed(gain_regs[2][63:48]), s.pitch_angle);
    y = pid_update(3, y, s.rate_y);
    z = pid_update(4, $signed(gain_regs[4][63:48]), s.yaw_angle);
    z = pid_update(5, z, s.rate_z);
    h = pid_update(6, $signed(gain_regs[6][63:48]), s.height);
    d.front = DrvW'(x - y + z + h);
    d.rear  = DrvW'(-x + y + z + h);
    d.left  = DrvW'(x - y - z + h);
    d.right = DrvW'(-x + y - z + h);
    return d;
  endfunction

  function automatic sample_t random_sample(bit wide);
    sample_t s;
    if (wide) begin
      s = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom)};
    end else begin
      // Moderate values keep most controllers out of saturation.
      s.roll_angle = 16'(int'($urandom_range(0, 4095)) - 2048);
      s.pitch_angle = 16'(int'($urandom_range(0, 4095)) - 2048);
      s.yaw_angle = 16'(int'($urandom_range(0, 4095)) - 2048);
      s.rate_x = 16'(int'($urandom_range(0, 4095)) - 2048);
      s.rate_y = 16'(int'($urandom_range(0, 4095)) - 2048);
      s.rate_z = 16'(int'($urandom_range(0, 4095)) - 2048);
      s.height = 16'(int'($urandom_range(0, 4095)) - 2048);
    end
    return s;
  endfunction

  // Writes one gain register through the configuration channel. Indexes past
  // the last controller are ignored by the block and by the predictor.
  task automatic write_gain(logic [IdxW-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx < Loops) begin
      if (idx == capm_pkg::IDX_ROLL_RATE || idx == capm_pkg::IDX_PITCH_RATE ||
          idx == capm_pkg::IDX_YAW_RATE)
        value[63:48] = '0;
      gain_regs[idx] = value;
    end
  endtask

  // Sends one word and records the predicted drive values. Valid stays high
  // after acceptance so that a following word can go out back to back.
  task automatic send_sample(sample_t s);
    bit idle;
    idle = sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct;
    if (idle) in_valid <= 1'b0;
    while (idle) begin
      @(posedge clk);
      idle = $urandom_range(0, 99) < sender_idle_pct;
    end
    in_valid <= 1'b1;
    {in_roll_angle, in_pitch_angle, in_yaw_angle} <= {s.roll_angle, s.pitch_angle, s.yaw_angle};
    {in_rate_x, in_rate_y, in_rate_z, in_height} <= {s.rate_x, s.rate_y, s.rate_z, s.height};
    do @(posedge clk); while (in_stall);
    expected_drives.push_back(mix_sample(s));
  endtask

  // Waits until every expected word has come back, then lets the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random gains: small ones mostly so that outputs stay in range, with the
  // occasional full 64-bit pattern to exercise the extreme values.
  task automatic write_random_gains(bit full);
    logic [63:0] v;
    for (int i = 0; i < Loops; i++) begin
      if (full) begin
        v = {$urandom, $urandom};
      end else begin
        v[15:0] = 16'(int'($urandom_range(0, 1023)) - 512);
        v[31:16] = 16'(int'($urandom_range(0, 63)) - 32);
        v[47:32] = 16'(int'($urandom_range(0, 511)) - 256);
        v[63:48] = 16'(int'($urandom_range(0, 8191)) - 4096);
      end
      write_gain(i[IdxW-1:0], v);
    end
  endtask

  // Receiver: stalls at random, and holds off for a long stretch on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_cycles <= HoldOffCycles;
      out_stall <= 1'b1;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_idle_pct > 0 && $urandom_range(0, 99) < receiver_idle_pct;
    end
  end

  // Result checker: each accepted word is compared with the oldest expectation.
  always @(posedge clk) begin
    drive_t exp_d;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_drives.size() == 0) begin
        $error("unexpected output word");
        error_count++;
      end else begin
        exp_d = expected_drives.pop_front();
        if (out_front_drive !== exp_d.front) begin
          $error("front_drive expected %0d got %0d", exp_d.front, out_front_drive);
          error_count++;
        end
        if (out_rear_drive !== exp_d.rear) begin
          $error("rear_drive expected %0d got %0d", exp_d.rear, out_rear_drive);
          error_count++;
        end
        if (out_left_drive !== exp_d.left) begin
          $error("left_drive expected %0d got %0d", exp_d.left, out_left_drive);
          error_count++;
        end
        if (out_right_drive !== exp_d.right) begin
          $error("right_drive expected %0d got %0d", exp_d.right, out_right_drive);
          error_count++;
        end
      end
    end
  end

  // Known-answer checker for directed rows whose result is read off directly.
  task automatic check_known(drive_t want);
    drive_t got;
    got = expected_drives[expected_drives.size() - 1];
    if (got !== want) begin
      $error("directed row: expected %0d/%0d/%0d/%0d predicted %0d/%0d/%0d/%0d",
             want.front, want.rear, want.left, want.right,
             got.front, got.rear, got.left, got.right);
      known_error_count++;
    end
  endtask

  // Watchdog: about 1800 words, with the stalls and settling pauses, take under
  // 7 ms, so 50 ms of simulated time is ample.
  initial begin
    #50ms;
    $display("cascaded_attitude_pid_mixer_tb: errors");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    sample_t s;
    for (int i = 0; i < Loops; i++) begin
      gain_regs[i] = '0;
      integrals[i] = '0;
      last_errors[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With every gain at zero after reset, all drives must be zero whatever
    // the samples are, including both extremes of every field.
    row.known = 1'b1;
    row.drv = '0;
    row.smp = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    rows.push_back(row);
    row.smp = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    rows.push_back(row);
    row.smp = '{default: '0};
    rows.push_back(row);
    foreach (rows[i]) begin
      send_sample(rows[i].smp);
      if (rows[i].known) check_known(rows[i].drv);
    end
    drain_results();

    // Extreme gains with extreme samples: controller saturation in both
    // directions, integral growth, and floor rounding of negative totals.
    // The out-of-range index must be ignored.
    for (int i = 0; i < Loops; i++)
      write_gain(i[IdxW-1:0], {16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
    write_gain(IdxW'(Loops), '1);
    rows.delete();
    row.known = 1'b0;
    for (int i = 0; i < 6; i++) begin
      row.smp = (i % 2) ? '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                            16'sh7fff, 16'sh7fff}
                        : '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh8000};
      rows.push_back(row);
    end
    foreach (rows[i]) send_sample(rows[i].smp);
    drain_results();

    // Small negative gains give negative totals that are not multiples of 256.
    for (int i = 0; i < Loops; i++)
      write_gain(i[IdxW-1:0], {16'sh0013, 16'shffff, 16'sh0001, 16'shff81});
    for (int i = 0; i < 8; i++) send_sample(random_sample(i % 2));
    drain_results();

    // The most negative goal with a unit integral gain makes the integrals grow.
    for (int i = 0; i < Loops; i++)
      write_gain(i[IdxW-1:0], {16'sh8000, 16'sh0000, 16'sh0001, 16'sh0000});
    for (int i = 0; i < 8; i++) send_sample('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                                              16'sh7fff, 16'sh7fff, 16'sh7fff});
    drain_results();

    // Random phases: receiver mostly idles, then sender mostly idles, then neither.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 87 : 0;
      receiver_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 35 : 0;
      for (int n = 0; n < RandomWords / 3; n++) begin
        if (n % 100 == 0) begin
          drain_results();
          write_random_gains(n % 300 == 200);
        end
        // A long receiver hold-off while words keep coming, so the block backs up.
        if (phase == 2 && n == 50) hold_off_reqs++;
        send_sample(random_sample($urandom_range(0, 4) == 0));
      end
    end
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    drain_results();

    if (error_count == 0 && known_error_count == 0) begin
      $display("cascaded_attitude_pid_mixer_tb: clean");
    end else begin
      $display("cascaded_attitude_pid_mixer_tb: errors");
    end
    $finish;
  end
endmodule
